>>> sv/header_value_tokenizer_assert.svh
// assertion macros for the header value tokenizer
`ifndef HEADER_VALUE_TOKENIZER_ASSERT_SVH
`define HEADER_VALUE_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HVT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hvt_pkg.sv
// shared types and constants of the header value tokenizer
package hvt_pkg;

    localparam int MAX_COMMENT_DEPTH = 15;
    localparam logic [3:0] DEPTH_CAP =
        4'((MAX_COMMENT_DEPTH < 15) ? MAX_COMMENT_DEPTH : 15);

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_EMPTY_QUOT = 3'd1;
    localparam logic [2:0] ERR_EMPTY_URI  = 3'd2;
    localparam logic [2:0] ERR_SECOND_EQ  = 3'd3;
    localparam logic [2:0] ERR_NESTED_URI = 3'd4;
    localparam logic [2:0] ERR_STRAY_GT   = 3'd5;
    localparam logic [2:0] ERR_COMMENT    = 3'd6;

    localparam int RUN_MAX = 4;

    typedef enum logic [2:0] {
        KIND_APPEND     = 3'd0,
        KIND_WORD       = 3'd1,
        KIND_DISCARD    = 3'd2,
        KIND_PNAME      = 3'd3,
        KIND_PNAME_ONLY = 3'd4,
        KIND_PVALUE     = 3'd5,
        KIND_OK         = 3'd6,
        KIND_REJECT     = 3'd7
    } kind_t;

    // all events caused by one character; append only in slot 0, reject only last
    typedef struct packed {
        kind_t [RUN_MAX-1:0] kinds;
        logic [2:0]          cnt;
        logic [7:0]          ch;
        logic [2:0]          err;
    } run_t;

    typedef struct packed {
        logic       in_quote;
        logic       in_uri;
        logic       in_param;
        logic [3:0] comment_depth;
        logic       token_nonempty;
        logic       param_name_set;
        logic       value_failed;
    } tok_state_t;

endpackage

>>> sv/hvt_if.sv
// valid/ready channel interfaces for characters and token events
interface hvt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;
    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

interface hvt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [2:0] error_code;
    logic       last_of_run;
    modport source (output valid, output kind, output char_out, output error_code,
                    output last_of_run, input ready);
    modport sink (input valid, input kind, input char_out, input error_code,
                  input last_of_run, output ready);
endinterface

>>> sv/hvt_front.sv
// front end: accepts characters, keeps tokenizer state, builds event runs
module hvt_front
    import hvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hvt_in_if.sink      din,
    input  logic        q_full,
    output logic        push,
    output run_t        push_run,
    output tok_state_t  status
);

    tok_state_t st_reg;
    tok_state_t st_next;
    run_t       run_c;
    logic [2:0] err_c;
    logic       app_c;
    logic       endc_hit;
    logic       accept;

    assign din.ready = !q_full;
    assign accept    = din.valid && din.ready;
    assign push      = accept && (run_c.cnt != 3'd0);
    assign push_run  = run_c;
    assign status    = st_reg;

    always_comb
    begin
        st_next  = st_reg;
        run_c    = '0;
        run_c.ch = din.ch;
        err_c    = ERR_NONE;
        app_c    = 1'b0;
        endc_hit = 1'b0;

        if (st_reg.value_failed)
        begin
            if (din.last)
                st_next = '0;
        end
        else
        begin
            app_c = st_reg.in_uri || (st_reg.in_quote && din.ch != CH_DQUOTE) ||
                    (din.ch != CH_SPACE && din.ch != CH_DQUOTE && din.ch != CH_SEMI &&
                     din.ch != CH_LPAREN && din.ch != CH_RPAREN &&
                     !(din.ch == CH_EQ && st_reg.in_param) &&
                     st_reg.comment_depth == 4'd0);
            if (app_c)
            begin
                run_c.kinds[0]         = KIND_APPEND;
                run_c.cnt              = 3'd1;
                st_next.token_nonempty = 1'b1;
            end

            // token boundaries, only outside comments
            if (st_reg.comment_depth == 4'd0)
            begin
                if (st_reg.in_quote || st_reg.in_uri)
                begin
                    endc_hit = st_reg.in_quote ? (din.ch == CH_DQUOTE) : (din.ch == CH_GT);
                    if (endc_hit && !st_reg.in_param)
                    begin
                        if (!st_next.token_nonempty)
                            err_c = st_reg.in_quote ? ERR_EMPTY_QUOT : ERR_EMPTY_URI;
                        else
                        begin
                            run_c.kinds[run_c.cnt[1:0]] = KIND_WORD;
                            run_c.cnt                   = run_c.cnt + 3'd1;
                            st_next.token_nonempty      = 1'b0;
                        end
                    end
                end
                else if (din.ch == CH_SPACE)
                begin
                    if (st_next.token_nonempty)
                    begin
                        run_c.kinds[run_c.cnt[1:0]] =
                            st_reg.in_param ? KIND_DISCARD : KIND_WORD;
                        run_c.cnt = run_c.cnt + 3'd1;
                    end
                    st_next.token_nonempty = 1'b0;
                end
                else if (st_reg.in_param)
                begin
                    if (din.ch == CH_EQ)
                    begin
                        if (st_reg.param_name_set)
                            err_c = ERR_SECOND_EQ;
                        else if (st_next.token_nonempty)
                        begin
                            run_c.kinds[run_c.cnt[1:0]] = KIND_PNAME;
                            run_c.cnt                   = run_c.cnt + 3'd1;
                            st_next.param_name_set      = 1'b1;
                            st_next.token_nonempty      = 1'b0;
                        end
                    end
                    else if (din.ch == CH_SEMI)
                    begin
                        run_c.kinds[run_c.cnt[1:0]] =
                            st_next.param_name_set ? KIND_PVALUE : KIND_PNAME_ONLY;
                        run_c.cnt              = run_c.cnt + 3'd1;
                        st_next.token_nonempty = 1'b0;
                        st_next.param_name_set = 1'b0;
                    end
                end
                else if (din.ch == CH_SEMI && st_next.token_nonempty)
                begin
                    run_c.kinds[run_c.cnt[1:0]] = KIND_WORD;
                    run_c.cnt                   = run_c.cnt + 3'd1;
                    st_next.token_nonempty      = 1'b0;
                end
            end

            // mode changes
            if (err_c == ERR_NONE)
            begin
                if (din.ch == CH_DQUOTE)
                    st_next.in_quote = !st_reg.in_quote;
                else if (din.ch == CH_LT)
                begin
                    if (st_reg.in_uri)
                        err_c = ERR_NESTED_URI;
                    else
                        st_next.in_uri = 1'b1;
                end
                else if (din.ch == CH_GT)
                begin
                    if (!st_reg.in_uri)
                        err_c = ERR_STRAY_GT;
                    else
                        st_next.in_uri = 1'b0;
                end
                else if (din.ch == CH_LPAREN)
                begin
                    if (st_reg.comment_depth >= DEPTH_CAP)
                        err_c = ERR_COMMENT;
                    else
                        st_next.comment_depth = st_reg.comment_depth + 4'd1;
                end
                else if (din.ch == CH_RPAREN)
                begin
                    if (st_reg.comment_depth == 4'd0)
                        err_c = ERR_COMMENT;
                    else
                        st_next.comment_depth = st_reg.comment_depth - 4'd1;
                end
                else if (!st_reg.in_uri && !st_reg.in_quote && din.ch == CH_SEMI)
                    st_next.in_param = 1'b1;
            end

            if (err_c != ERR_NONE)
            begin
                run_c.kinds[run_c.cnt[1:0]] = KIND_REJECT;
                run_c.cnt                   = run_c.cnt + 3'd1;
                run_c.err                   = err_c;
                if (din.last)
                    st_next = '0;
                else
                    st_next.value_failed = 1'b1;
            end
            else if (din.last)
            begin
                if (st_next.in_param)
                begin
                    run_c.kinds[run_c.cnt[1:0]] =
                        st_next.param_name_set ? KIND_PVALUE : KIND_PNAME_ONLY;
                    run_c.cnt = run_c.cnt + 3'd1;
                end
                else if (st_next.token_nonempty)
                begin
                    run_c.kinds[run_c.cnt[1:0]] = KIND_WORD;
                    run_c.cnt                   = run_c.cnt + 3'd1;
                end
                run_c.kinds[run_c.cnt[1:0]] = KIND_OK;
                run_c.cnt                   = run_c.cnt + 3'd1;
                st_next                     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (accept)
            st_reg <= st_next;
    end

endmodule

>>> sv/hvt_queue.sv
// two-entry queue of event runs between front and back end
module hvt_queue
    import hvt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_run,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output run_t head
);

    run_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/hvt_back.sv
// back end: walks each run and sends one event beat per cycle while the sink is ready
module hvt_back
    import hvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  run_t       head,
    output logic       pop,
    hvt_out_if.source  dout
);

    logic       out_valid_reg;
    kind_t      kind_reg;
    logic [7:0] char_reg;
    logic [2:0] err_reg;
    logic       lor_reg;
    logic [1:0] idx_reg;
    logic       load;
    logic       last_ev;
    kind_t      cur_kind;

    assign load     = head_valid && (!out_valid_reg || dout.ready);
    assign last_ev  = ({1'b0, idx_reg} == (head.cnt - 3'd1));
    assign pop      = load && last_ev;
    assign cur_kind = head.kinds[idx_reg];

    assign dout.valid       = out_valid_reg;
    assign dout.kind        = kind_reg;
    assign dout.char_out    = char_reg;
    assign dout.error_code  = err_reg;
    assign dout.last_of_run = lor_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= cur_kind;
            char_reg <= (cur_kind == KIND_APPEND) ? head.ch : 8'd0;
            err_reg  <= (cur_kind == KIND_REJECT) ? head.err : ERR_NONE;
            lor_reg  <= last_ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= last_ev ? 2'd0 : idx_reg + 2'd1;
        end
        else if (dout.ready)
            out_valid_reg <= 1'b0;
    end

endmodule

>>> sv/header_value_tokenizer.sv
// top level of the header value tokenizer
// Takes one character beat per cycle while the run queue has room; last marks the
// final character of a header value. It sends token event beats: append, word done,
// discard, parameter name and completion, value accepted or rejected with an error code.
// A character causes zero to three events; last_of_run flags the final event of a
// character. The front end classifies a character combinationally and accepts a new
// one every cycle while the two-entry run queue has room. The back end sends one
// event beat per cycle through its output register while the sink is ready; a
// character with no events puts no run into the queue. With an empty queue the first
// event of a character passes through the run queue and then the output register
// before it is offered. No clearing pass after reset.
`include "header_value_tokenizer_assert.svh"

module header_value_tokenizer
    import hvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hvt_in_if.sink     din,
    hvt_out_if.source  dout
);

    // run handoff between front end, queue and back end
    logic       push;
    run_t       push_run;
    logic       q_full;
    logic       pop;
    logic       head_valid;
    run_t       head;
    tok_state_t front_status;

    // front end: tokenizer state and event classification
    hvt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .din      (din),
        .q_full   (q_full),
        .push     (push),
        .push_run (push_run),
        .status   (front_status)
    );

    // decouples character intake from event delivery
    hvt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back end: serializes each run onto the output channel
    hvt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .dout       (dout)
    );

    // a queued run always holds between one and four events
    `HVT_ASSERT_SAME(a_run_count, head_valid, (head.cnt != 3'd0) && (head.cnt <= 3'd4), "run count out of range")
    // the final character of a value leaves the tokenizer at reset state
    `HVT_ASSERT_NEXT(a_last_clears, din.valid && din.ready && din.last, front_status == '0, "state not cleared after last")
    // a rejection carries a code and ends its run
    `HVT_ASSERT_SAME(a_reject_code, dout.valid && (dout.kind == KIND_REJECT), (dout.error_code != ERR_NONE) && dout.last_of_run, "bad reject beat")

endmodule

>>> tb/sv/header_value_tokenizer_checker.sv
// event predictor and beat checker for the header value tokenizer
`timescale 1ns / 100ps

module header_value_tokenizer_checker
    import hvt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hvt_in_if    din,
    hvt_out_if   dout,
    output int   mismatches,
    output int   outstanding
);

    typedef struct {
        kind_t      kind;
        logic [7:0] ch;
        logic [2:0] err;
        logic       lor;
    } token_event_t;

    token_event_t expected_events[$];
    token_event_t char_events[$];
    tok_state_t   tok;
    int           fails;

    function automatic void add_event(kind_t k, logic [7:0] c, logic [2:0] e);
        if (char_events.size() < RUN_MAX)
        begin
            char_events.insert(char_events.size(), '{k, c, e, 1'b0});
        end
    endfunction

    function automatic void close_param();
        if (tok.param_name_set)
        begin
            add_event(KIND_PVALUE, 8'h00, ERR_NONE);
        end
        else
        begin
            add_event(KIND_PNAME_ONLY, 8'h00, ERR_NONE);
        end
        tok.token_nonempty = 1'b0;
        tok.param_name_set = 1'b0;
    endfunction

    // events of one character, error code if it breaks the value
    function automatic logic [2:0] scan_char(logic [7:0] c);
        logic       app;
        logic [7:0] endc;
        app = tok.in_uri || (tok.in_quote && c != CH_DQUOTE) ||
              (c != CH_SPACE && c != CH_DQUOTE && c != CH_SEMI && c != CH_LPAREN &&
               c != CH_RPAREN && !(c == CH_EQ && tok.in_param) &&
               tok.comment_depth == 4'd0);
        if (app)
        begin
            add_event(KIND_APPEND, c, ERR_NONE);
            tok.token_nonempty = 1'b1;
        end
        if (tok.comment_depth == 4'd0)
        begin
            if (tok.in_quote || tok.in_uri)
            begin
                endc = tok.in_quote ? CH_DQUOTE : CH_GT;
                if (c == endc && !tok.in_param)
                begin
                    if (!tok.token_nonempty)
                        return tok.in_quote ? ERR_EMPTY_QUOT : ERR_EMPTY_URI;
                    add_event(KIND_WORD, 8'h00, ERR_NONE);
                    tok.token_nonempty = 1'b0;
                end
            end
            else if (c == CH_SPACE)
            begin
                if (tok.token_nonempty)
                begin
                    if (tok.in_param)
                        add_event(KIND_DISCARD, 8'h00, ERR_NONE);
                    else
                        add_event(KIND_WORD, 8'h00, ERR_NONE);
                end
                tok.token_nonempty = 1'b0;
            end
            else if (tok.in_param)
            begin
                if (c == CH_EQ)
                begin
                    if (tok.param_name_set)
                        return ERR_SECOND_EQ;
                    if (tok.token_nonempty)
                    begin
                        add_event(KIND_PNAME, 8'h00, ERR_NONE);
                        tok.param_name_set = 1'b1;
                        tok.token_nonempty = 1'b0;
                    end
                end
                else if (c == CH_SEMI)
                begin
                    close_param();
                end
            end
            else if (c == CH_SEMI && tok.token_nonempty)
            begin
                add_event(KIND_WORD, 8'h00, ERR_NONE);
                tok.token_nonempty = 1'b0;
            end
        end
        if (c == CH_DQUOTE)
        begin
            tok.in_quote = !tok.in_quote;
        end
        else if (c == CH_LT)
        begin
            if (tok.in_uri)
                return ERR_NESTED_URI;
            tok.in_uri = 1'b1;
        end
        else if (c == CH_GT)
        begin
            if (!tok.in_uri)
                return ERR_STRAY_GT;
            tok.in_uri = 1'b0;
        end
        else if (c == CH_LPAREN)
        begin
            if (tok.comment_depth >= DEPTH_CAP)
                return ERR_COMMENT;
            tok.comment_depth = tok.comment_depth + 4'd1;
        end
        else if (c == CH_RPAREN)
        begin
            if (tok.comment_depth == 4'd0)
                return ERR_COMMENT;
            tok.comment_depth = tok.comment_depth - 4'd1;
        end
        else if (!tok.in_uri && !tok.in_quote && c == CH_SEMI)
        begin
            tok.in_param = 1'b1;
        end
        return ERR_NONE;
    endfunction

    function automatic void predict_char(logic [7:0] c, logic lst);
        logic [2:0] err;
        char_events.delete();
        if (tok.value_failed)
        begin
            // swallowed until the last flag
            if (lst)
                tok = '0;
            return;
        end
        err = scan_char(c);
        if (err != ERR_NONE)
        begin
            add_event(KIND_REJECT, 8'h00, err);
            if (lst)
                tok = '0;
            else
                tok.value_failed = 1'b1;
        end
        else if (lst)
        begin
            if (tok.in_param)
                close_param();
            else if (tok.token_nonempty)
                add_event(KIND_WORD, 8'h00, ERR_NONE);
            add_event(KIND_OK, 8'h00, ERR_NONE);
            tok = '0;
        end
        if (char_events.size() > 0)
            char_events[char_events.size() - 1].lor = 1'b1;
        foreach (char_events[i])
            expected_events.insert(expected_events.size(), char_events[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        token_event_t want;
        if (!rst_n)
        begin
            tok = '0;
            fails = 0;
            expected_events.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (din.valid && din.ready)
                predict_char(din.ch, din.last);
            if (dout.valid && dout.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected beat: kind %0d char %02h err %0d last %0b",
                                 dout.kind, dout.char_out, dout.error_code,
                                 dout.last_of_run);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (dout.kind !== want.kind || dout.char_out !== want.ch ||
                        dout.error_code !== want.err || dout.last_of_run !== want.lor)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch: exp kind %0d char %02h err %0d last %0b",
                                      " / got kind %0d char %02h err %0d last %0b"},
                                     want.kind, want.ch, want.err, want.lor,
                                     dout.kind, dout.char_out, dout.error_code,
                                     dout.last_of_run);
                    end
                end
            end
            mismatches <= fails;
            outstanding <= expected_events.size();
        end
    end

endmodule

>>> tb/sv/header_value_tokenizer_test.sv
// top of the header value tokenizer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module header_value_tokenizer_test
    import hvt_pkg::*;
();

    // generous bound, far above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;
    // cycle at which the sink stops taking beats for a while
    localparam int HOLD_START  = 1500;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 460;

    localparam logic [7:0] SPECIALS [8] = '{CH_DQUOTE, CH_GT, CH_LT, CH_SEMI,
                                            CH_EQ, CH_LPAREN, CH_RPAREN, CH_SPACE};

    logic clk;
    logic rst_n;
    int   cycle = 0;
    int   mismatches;
    int   outstanding;
    int   sent_items;
    logic calm;     // no idling on either side while set
    logic hold;     // long sink hold-off
    logic [7:0] value_bytes[$];

    hvt_in_if  din ();
    hvt_out_if dout ();

    header_value_tokenizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    header_value_tokenizer_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .din         (din),
        .dout        (dout),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // reset held from the start, released once
    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
        cycle <= cycle + 1;

    // watchdog
    initial
    begin
        while (cycle < CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // one long stall of the sink so the block fills up and drops din.ready
    initial
    begin
        hold = 1'b0;
        while (cycle < HOLD_START) @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    // event sink: after each beat it takes, ready drops for a random stall, possibly none
    initial
    begin : sink
        int stall;
        stall = 0;
        dout.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (dout.valid && dout.ready)
                stall = calm ? 0 : $urandom_range(0, 11);
            if (hold)
            begin
                dout.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                dout.ready <= 1'b0;
                stall--;
            end
            else
            begin
                dout.ready <= 1'b1;
            end
        end
    end

    // one character beat: random gap first, then hold valid until taken
    task automatic send_char(logic [7:0] c, logic lst);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din.valid <= 1'b1;
        din.ch    <= c;
        din.last  <= lst;
        @(posedge clk);
        while (!din.ready) @(posedge clk);
        sent_items++;
    endtask

    // a whole value, last flag on its final character
    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_value_bytes();
        for (int i = 0; i < value_bytes.size(); i++)
            send_char(value_bytes[i], i == value_bytes.size() - 1);
    endtask

    // appends one byte to the value under construction
    function automatic void put_byte(logic [7:0] b);
        value_bytes.insert(value_bytes.size(), b);
    endfunction

    // any byte that is not one of the syntax characters
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        foreach (SPECIALS[i])
            if (c == SPECIALS[i])
                c = 8'($urandom_range(8'h61, 8'h7a));
        return c;
    endfunction

    function automatic void add_word();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) put_byte(plain_char());
    endfunction

    // builds one value: mostly well-formed segments, some noise and broken ones
    function automatic void random_value();
        int shape;
        int nseg;
        int n;
        value_bytes.delete();
        shape = $urandom_range(0, 9);
        if (shape <= 5)
        begin
            nseg = $urandom_range(1, 4);
            repeat (nseg)
            begin
                case ($urandom_range(0, 6))
                    0: add_word();
                    1:
                    begin
                        put_byte(CH_DQUOTE);
                        add_word();
                        put_byte(CH_DQUOTE);
                    end
                    2:
                    begin
                        put_byte(CH_LT);
                        add_word();
                        put_byte(CH_GT);
                    end
                    3:
                    begin
                        put_byte(CH_SEMI);
                        add_word();
                        put_byte(CH_EQ);
                        add_word();
                    end
                    4:
                    begin
                        put_byte(CH_SEMI);
                        add_word();
                    end
                    5: put_byte(CH_SPACE);
                    default:
                    begin
                        // comment, sometimes nested, sometimes with quoted text
                        n = $urandom_range(1, 2);
                        repeat (n) put_byte(CH_LPAREN);
                        if ($urandom_range(0, 1))
                            put_byte(CH_DQUOTE);
                        add_word();
                        if ($urandom_range(0, 1))
                            put_byte(CH_DQUOTE);
                        repeat (n) put_byte(CH_RPAREN);
                    end
                endcase
            end
        end
        else if (shape <= 7)
        begin
            // noise, heavy on syntax characters
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                if ($urandom_range(0, 1))
                    put_byte(SPECIALS[$urandom_range(0, 7)]);
                else
                    put_byte(8'($urandom_range(0, 255)));
            end
        end
        else if (shape == 8)
        begin
            // comment depth just below, at and just past the bound
            n = int'(DEPTH_CAP) - 1 + $urandom_range(0, 2);
            repeat (n) put_byte(CH_LPAREN);
            n = $urandom_range(0, 3);
            repeat (n) put_byte(CH_RPAREN);
            add_word();
        end
        else
        begin
            // a word broken by one or two stray syntax characters
            add_word();
            put_byte(SPECIALS[$urandom_range(0, 7)]);
            if ($urandom_range(0, 1))
                put_byte(SPECIALS[$urandom_range(0, 7)]);
            add_word();
        end
    endfunction

    initial
    begin
        din.valid  = 1'b0;
        din.ch     = 8'h00;
        din.last   = 1'b0;
        calm       = 1'b0;
        sent_items = 0;
        while (!rst_n) @(posedge clk);

        // directed values
        send_char(8'h00, 1'b1);             // lowest byte as a one-character word
        send_char(8'hff, 1'b0);             // highest byte, then words and parameters
        send_text(" x;n=v w;q");            // word, name, discard, value, name-only
        send_text("\"\"z");                  // empty quote, rest swallowed
        send_text("<>");                    // brackets appended as a word, value accepted
        send_text(";a==");                  // second equals sign
        send_text(">");                     // stray closing bracket
        send_text("(a\"b\")");              // quoted text inside a comment

        // random values until the item budget is used
        while (sent_items < RANDOM_ITEMS + 28)
        begin
            if ($urandom_range(0, 7) == 0)
                calm <= !calm;
            random_value();
            send_value_bytes();
        end
        din.valid <= 1'b0;
        calm <= 1'b0;

        // drain: wait for the checker's registered count to settle and reach zero
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
